>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check sampled on clk_i, muted while rst_ni is low.
`define TDCC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that must also hold while reset is applied.
`define TDCC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/tdcc_pkg.sv
package tdcc_pkg;

  // display / tile limits
  localparam int unsigned MAX_WIDTH  = 640;
  localparam int unsigned MAX_HEIGHT = 480;
  localparam int unsigned MAX_TILE   = 64;

  // config register widths
  localparam int unsigned DW_W  = 10;
  localparam int unsigned DH_W  = 9;
  localparam int unsigned TS_W  = 7;
  localparam int unsigned OFS_W = 16;

  // config register index, byte address 4*index
  typedef enum logic [2:0] {
    REG_DISPLAY_WIDTH  = 3'd0,
    REG_DISPLAY_HEIGHT = 3'd1,
    REG_TILE_SIZE      = 3'd2,
    REG_OFFSET_X       = 3'd3,
    REG_OFFSET_Y       = 3'd4
  } cfg_reg_e;

  // beat field widths
  localparam int unsigned PIXEL_W   = 32;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned RECT_XY_W = 17;
  localparam int unsigned RECT_WH_W = 7;
  localparam int unsigned COUNT_W   = 19;

  // position counters
  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
  localparam int unsigned TIT_W = $clog2(MAX_TILE);

  // canvas memory
  localparam int unsigned CANVAS_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned CANVAS_AW    = $clog2(CANVAS_DEPTH);

  // tile column flags, packed into rows of FLAG_ROW_W bits
  localparam int unsigned FLAG_ROW_W = 8;
  localparam int unsigned FLAG_BIT_W = $clog2(FLAG_ROW_W);
  localparam int unsigned FLAG_ROWS  = (MAX_WIDTH + FLAG_ROW_W - 1) / FLAG_ROW_W;
  localparam int unsigned FLAG_AW    = $clog2(FLAG_ROWS);

  typedef struct packed {
    logic [RECT_XY_W-1:0] rect_x;
    logic [RECT_XY_W-1:0] rect_y;
    logic [RECT_WH_W-1:0] rect_w;
    logic [RECT_WH_W-1:0] rect_h;
    logic                 frame_end;
    logic [COUNT_W-1:0]   changed_tiles;
    logic                 last;
  } res_t;

endpackage

>>> src/tdcc_ifs.sv
interface tdcc_pix_if import tdcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface tdcc_res_if import tdcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RECT_XY_W-1:0] rect_x;
  logic [RECT_XY_W-1:0] rect_y;
  logic [RECT_WH_W-1:0] rect_w;
  logic [RECT_WH_W-1:0] rect_h;
  logic                 frame_end;
  logic [COUNT_W-1:0]   changed_tiles;
  logic                 last;

  modport source (output valid, output rect_x, output rect_y, output rect_w,
                  output rect_h, output frame_end, output changed_tiles,
                  output last, input ready);
  modport sink   (input valid, input rect_x, input rect_y, input rect_w,
                  input rect_h, input frame_end, input changed_tiles,
                  input last, output ready);
endinterface

>>> src/tdcc_ram.sv
module tdcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/tile_dirty_compare_copy_top.sv
// Path: a pixel is registered into stage B at accept; stage B fills the output queue.
// Throughput: one pixel per cycle while pix_i.ready is high, set by the single canvas
//   read-modify-write per pixel; pix_i.ready drops when the queue lacks room.
//   Up to two beats per pixel drain an 8-entry queue, one per cycle of res_o.ready.
// Reset: async, active low. Registers return to 640/480/16/0/0; a clearing pass then
//   zeroes the canvas memory, one entry a cycle, with pix_i.ready low until it ends.
`include "assert_macros.svh"

module tile_dirty_compare_copy_top import tdcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tdcc_pix_if.sink    pix_i,
  tdcc_res_if.source  res_o,
  // APB config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers, byte address 4*index
  // ---------------------------------------------------------------------------
  logic [DW_W-1:0]  dw_q;
  logic [DH_W-1:0]  dh_q;
  logic [TS_W-1:0]  ts_q;
  logic [OFS_W-1:0] ox_q;
  logic [OFS_W-1:0] oy_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dw_q <= DW_W'(MAX_WIDTH);
      dh_q <= DH_W'(MAX_HEIGHT);
      ts_q <= TS_W'(16);
      ox_q <= '0;
      oy_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_DISPLAY_WIDTH:  dw_q <= pwdata[DW_W-1:0];
        REG_DISPLAY_HEIGHT: dh_q <= pwdata[DH_W-1:0];
        REG_TILE_SIZE:      ts_q <= pwdata[TS_W-1:0];
        REG_OFFSET_X:       ox_q <= pwdata[OFS_W-1:0];
        REG_OFFSET_Y:       oy_q <= pwdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_DISPLAY_WIDTH:  prdata = 32'(dw_q);
      REG_DISPLAY_HEIGHT: prdata = 32'(dh_q);
      REG_TILE_SIZE:      prdata = 32'(ts_q);
      REG_OFFSET_X:       prdata = 32'(ox_q);
      REG_OFFSET_Y:       prdata = 32'(oy_q);
      default:            prdata = '0;
    endcase
  end

  // Geometry in use: clamped to 1..max
  logic [DW_W-1:0] w_eff;
  logic [DH_W-1:0] h_eff;
  logic [TS_W-1:0] t_eff;

  always_comb begin
    if (dw_q == '0)                   w_eff = DW_W'(1);
    else if (dw_q > DW_W'(MAX_WIDTH)) w_eff = DW_W'(MAX_WIDTH);
    else                              w_eff = dw_q;

    if (dh_q == '0)                    h_eff = DH_W'(1);
    else if (dh_q > DH_W'(MAX_HEIGHT)) h_eff = DH_W'(MAX_HEIGHT);
    else                               h_eff = dh_q;

    if (ts_q == '0)                  t_eff = TS_W'(1);
    else if (ts_q > TS_W'(MAX_TILE)) t_eff = TS_W'(MAX_TILE);
    else                             t_eff = ts_q;
  end

  // Tile length clipped at the display edge; 0 when the tile starts past it.
  function automatic logic [RECT_WH_W-1:0] clip_len(input logic [TS_W-1:0] tile,
                                                    input logic [DW_W-1:0] limit,
                                                    input logic [DW_W-1:0] start);
    logic [DW_W-1:0] span;
    span = limit - start;
    if (start >= limit) begin
      return '0;
    end else if (span < DW_W'(tile)) begin
      return RECT_WH_W'(span);
    end else begin
      return RECT_WH_W'(tile);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Canvas clearing pass after reset
  // ---------------------------------------------------------------------------
  logic                 clr_busy_q;
  logic [CANVAS_AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + CANVAS_AW'(1);
      if (clr_addr_q == CANVAS_AW'(CANVAS_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: position tracking, addresses and tile geometry at accept
  // ---------------------------------------------------------------------------
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [CANVAS_AW-1:0]  addr;
    logic [COLOR_W-1:0]    color;
    logic [FLAG_AW-1:0]    frow;
    logic [FLAG_BIT_W-1:0] fbit;
    logic                  row_valid;   // flag row holds live data
    logic                  fwd_c;       // canvas word written at our read edge
    logic [COLOR_W-1:0]    fwd_color;
    logic                  fwd_f;       // flag row written at our read edge
    logic [FLAG_ROW_W-1:0] fwd_row;
    logic                  tile_end;
    logic                  frame_last;
    logic                  fs;
    logic [RECT_XY_W-1:0]  rect_x;
    logic [RECT_XY_W-1:0]  rect_y;
    logic [RECT_WH_W-1:0]  rect_w;
    logic [RECT_WH_W-1:0]  rect_h;
  } stage_t;

  logic [COL_W-1:0] col_q, col_d, cur_col, col_start;
  logic [ROW_W-1:0] row_q, row_d, cur_row, row_start;
  logic [TIT_W-1:0] cit_q, cit_d, cur_cit;
  logic [TIT_W-1:0] rit_q, rit_d, cur_rit;
  logic             row_end, row_last, frame_last, tcol_end, trow_end;
  logic [CANVAS_AW-1:0]  addr_a;
  logic [FLAG_AW-1:0]    frow_a;
  logic                  acc;
  logic [FIFO_CW-1:0]    fifo_cnt_q;

  stage_t b_q, b_d;
  logic   bv_q;
  logic [FLAG_ROWS-1:0]  valid_q;
  logic [FLAG_ROW_W-1:0] new_row;

  // Keep room for the pixel in stage B and the new one, two beats each.
  assign pix_i.ready = !clr_busy_q &&
                       ((fifo_cnt_q + (bv_q ? FIFO_CW'(2) : FIFO_CW'(0)))
                        <= FIFO_CW'(FIFO_DEPTH - 2));
  assign acc = pix_i.valid & pix_i.ready;

  always_comb begin
    cur_col = pix_i.frame_start ? '0 : col_q;
    cur_row = pix_i.frame_start ? '0 : row_q;
    cur_cit = pix_i.frame_start ? '0 : cit_q;
    cur_rit = pix_i.frame_start ? '0 : rit_q;

    row_end    = ((COL_W + 1)'(cur_col) + (COL_W + 1)'(1)) >= (COL_W + 1)'(w_eff);
    row_last   = ((ROW_W + 1)'(cur_row) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(h_eff);
    frame_last = row_end & row_last;
    tcol_end   = row_end  | ((TS_W'(cur_cit) + TS_W'(1)) >= t_eff);
    trow_end   = row_last | ((TS_W'(cur_rit) + TS_W'(1)) >= t_eff);

    col_start = cur_col - COL_W'(cur_cit);
    row_start = cur_row - ROW_W'(cur_rit);
    addr_a    = CANVAS_AW'(cur_row) * CANVAS_AW'(MAX_WIDTH) + CANVAS_AW'(cur_col);
    frow_a    = FLAG_AW'(col_start >> FLAG_BIT_W);

    // next raster position
    col_d = cur_col;
    row_d = cur_row;
    cit_d = cur_cit;
    rit_d = cur_rit;
    if (frame_last) begin
      col_d = '0;
      row_d = '0;
      cit_d = '0;
      rit_d = '0;
    end else if (row_end) begin
      col_d = '0;
      cit_d = '0;
      row_d = cur_row + ROW_W'(1);
      rit_d = trow_end ? '0 : cur_rit + TIT_W'(1);
    end else begin
      col_d = cur_col + COL_W'(1);
      cit_d = tcol_end ? '0 : cur_cit + TIT_W'(1);
    end

    b_d.addr       = addr_a;
    b_d.color      = pix_i.pixel[COLOR_W-1:0];
    b_d.frow       = frow_a;
    b_d.fbit       = col_start[FLAG_BIT_W-1:0];
    // flag row is live unless a frame start wipes it; stage B's write makes it live
    b_d.row_valid  = !pix_i.frame_start &&
                     ((bv_q && (b_q.frow == frow_a)) || valid_q[frow_a]);
    b_d.fwd_c      = bv_q && (b_q.addr == addr_a);
    b_d.fwd_color  = b_q.color;
    b_d.fwd_f      = bv_q && (b_q.frow == frow_a);
    b_d.fwd_row    = new_row;
    b_d.tile_end   = tcol_end & trow_end;
    b_d.frame_last = frame_last;
    b_d.fs         = pix_i.frame_start;
    b_d.rect_x     = RECT_XY_W'(ox_q) + RECT_XY_W'(col_start);
    b_d.rect_y     = RECT_XY_W'(oy_q) + RECT_XY_W'(row_start);
    b_d.rect_w     = clip_len(t_eff, w_eff, DW_W'(col_start));
    b_d.rect_h     = clip_len(t_eff, DW_W'(h_eff), DW_W'(row_start));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cit_q <= '0;
      rit_q <= '0;
      bv_q  <= 1'b0;
    end else begin
      bv_q <= acc;
      if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
        cit_q <= cit_d;
        rit_q <= rit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      b_q <= b_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Memories: canvas copy and packed tile-column flags
  // ---------------------------------------------------------------------------
  logic                  canvas_we;
  logic [CANVAS_AW-1:0]  canvas_waddr;
  logic [COLOR_W-1:0]    canvas_wdata;
  logic [COLOR_W-1:0]    canvas_rd;
  logic [FLAG_ROW_W-1:0] flag_rd;

  assign canvas_we    = clr_busy_q | bv_q;
  assign canvas_waddr = clr_busy_q ? clr_addr_q : b_q.addr;
  assign canvas_wdata = clr_busy_q ? '0 : b_q.color;

  tdcc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (CANVAS_DEPTH)
  ) u_canvas (
    .clk_i   (clk_i),
    .we_i    (canvas_we),
    .waddr_i (canvas_waddr),
    .wdata_i (canvas_wdata),
    .re_i    (acc),
    .raddr_i (addr_a),
    .rdata_o (canvas_rd)
  );

  tdcc_ram #(
    .WIDTH (FLAG_ROW_W),
    .DEPTH (FLAG_ROWS)
  ) u_flags (
    .clk_i   (clk_i),
    .we_i    (bv_q),
    .waddr_i (b_q.frow),
    .wdata_i (new_row),
    .re_i    (acc),
    .raddr_i (frow_a),
    .rdata_o (flag_rd)
  );

  // Row valid bits stand in for clearing the flags. A frame start on the
  // accepted pixel is newer than stage B's write, so the wipe wins.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (acc && pix_i.frame_start) begin
      valid_q <= '0;
    end else if (bv_q) begin
      valid_q[b_q.frow] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: compare, flag update, result generation
  // ---------------------------------------------------------------------------
  logic [COLOR_W-1:0]    old_color;
  logic [FLAG_ROW_W-1:0] old_row;
  logic                  flag_set, emit;
  logic [COUNT_W-1:0]    tcnt_q, cnt_base, cnt_new;
  logic [1:0]            push_n;
  res_t                  r_rect, r_end, r_first;

  always_comb begin
    old_color = b_q.fwd_c ? b_q.fwd_color : canvas_rd;
    old_row   = !b_q.row_valid ? '0 : (b_q.fwd_f ? b_q.fwd_row : flag_rd);
    flag_set  = old_row[b_q.fbit] | (old_color != b_q.color);
    emit      = b_q.tile_end & flag_set;

    new_row            = old_row;
    new_row[b_q.fbit]  = flag_set & ~emit;

    cnt_base = b_q.fs ? '0 : tcnt_q;
    cnt_new  = (emit && (cnt_base != '1)) ? cnt_base + COUNT_W'(1) : cnt_base;

    r_rect.rect_x        = b_q.rect_x;
    r_rect.rect_y        = b_q.rect_y;
    r_rect.rect_w        = b_q.rect_w;
    r_rect.rect_h        = b_q.rect_h;
    r_rect.frame_end     = 1'b0;
    r_rect.changed_tiles = cnt_new;
    r_rect.last          = ~b_q.frame_last;

    r_end.rect_x        = '0;
    r_end.rect_y        = '0;
    r_end.rect_w        = '0;
    r_end.rect_h        = '0;
    r_end.frame_end     = 1'b1;
    r_end.changed_tiles = cnt_new;
    r_end.last          = 1'b1;

    r_first = emit ? r_rect : r_end;
    push_n  = bv_q ? ({1'b0, emit} + {1'b0, b_q.frame_last}) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcnt_q <= '0;
    end else if (bv_q) begin
      tcnt_q <= b_q.frame_last ? '0 : cnt_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: up to two pushes per cycle, one pop per cycle
  // ---------------------------------------------------------------------------
  res_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q, wptr_nx;
  logic               pop;

  assign wptr_nx = wptr_q + FIFO_AW'(1);
  assign pop     = res_o.valid & res_o.ready;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wptr_q] <= r_first;
    end
    if (push_n == 2'd2) begin
      fifo_q[wptr_nx] <= r_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q     <= '0;
      rptr_q     <= '0;
      fifo_cnt_q <= '0;
    end else begin
      wptr_q     <= wptr_q + FIFO_AW'(push_n);
      rptr_q     <= rptr_q + FIFO_AW'(pop);
      fifo_cnt_q <= fifo_cnt_q + FIFO_CW'(push_n) - FIFO_CW'(pop);
    end
  end

  assign res_o.valid         = (fifo_cnt_q != '0);
  assign res_o.rect_x        = fifo_q[rptr_q].rect_x;
  assign res_o.rect_y        = fifo_q[rptr_q].rect_y;
  assign res_o.rect_w        = fifo_q[rptr_q].rect_w;
  assign res_o.rect_h        = fifo_q[rptr_q].rect_h;
  assign res_o.frame_end     = fifo_q[rptr_q].frame_end;
  assign res_o.changed_tiles = fifo_q[rptr_q].changed_tiles;
  assign res_o.last          = fifo_q[rptr_q].last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TDCC_ASSERT(a_fifo_bound, fifo_cnt_q <= FIFO_CW'(FIFO_DEPTH), "result queue overflow")
  `TDCC_ASSERT(a_fs_wipes_flags, acc && pix_i.frame_start |=> valid_q == '0, "flags not wiped")
  `TDCC_ASSERT(a_frame_count_zero, bv_q && b_q.frame_last |=> tcnt_q == '0, "count kept")
  `TDCC_ASSERT(a_end_is_last, res_o.valid && res_o.frame_end |-> res_o.last, "frame end not last")

endmodule

>>> tb/sv/tb_tile_dirty_compare_copy_top.sv
module tb_tile_dirty_compare_copy_top import tdcc_pkg::*; ();

  // Frame geometry families used by the random phases.
  typedef enum int unsigned {
    SHAPE_SMALL,
    SHAPE_WIDE,
    SHAPE_TALL
  } frame_shape_e;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               frame_start;
  } pix_beat_t;

  localparam int unsigned ITEM_TARGET  = 1720;       // directed + random pixels
  localparam int unsigned SETTLE_CYC   = 6;          // accept -> stage B -> queue -> output
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;  // clearing pass + slow run x3
  localparam int unsigned COUNT_LIMIT  = (1 << COUNT_W) - 1;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tdcc_pix_if pix ();
  tdcc_res_if res ();

  tile_dirty_compare_copy_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own canvas copy, tile column flags, raster position
  // and the register shadow. Canvas starts all zero, same as after the DUT's
  // clearing pass.
  // ---------------------------------------------------------------------------
  bit [COLOR_W-1:0]   canvas_copy [CANVAS_DEPTH];
  bit                 tile_dirty  [MAX_WIDTH];
  bit [COL_W-1:0]     col_pos;
  bit [ROW_W-1:0]     row_pos;
  bit [TIT_W-1:0]     col_in_tile;
  bit [TIT_W-1:0]     row_in_tile;
  bit [COUNT_W-1:0]   tiles_found;

  bit [DW_W-1:0]      cfg_width  = DW_W'(MAX_WIDTH);
  bit [DH_W-1:0]      cfg_height = DH_W'(MAX_HEIGHT);
  bit [TS_W-1:0]      cfg_tile   = TS_W'(16);
  bit [OFS_W-1:0]     cfg_ofs_x  = '0;
  bit [OFS_W-1:0]     cfg_ofs_y  = '0;

  res_t               tile_reports_due [$];  // rect / frame-end beats still owed
  pix_beat_t          pix_queue [$];         // pixels waiting for the driver

  int unsigned        pixels_left;   // queued or on the bus, not yet accepted
  int unsigned        sent_items;
  int unsigned        fail_count;
  int unsigned        cycle_count;
  bit                 src_idle_on  = 1'b1;
  bit                 sink_idle_on = 1'b1;

  // Clock; the single reset at start of run is in the main sequence.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Register values as the block uses them: 0 -> 1, over max -> max.
  function automatic int unsigned fit_range(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Tile extent clipped at the display edge; 0 if the tile starts past it
  // (only possible after a mid-frame shrink).
  function automatic int unsigned edge_clip(input int unsigned tile, input int unsigned limit,
                                            input int unsigned start);
    if (start >= limit) return 0;
    if (limit - start < tile) return limit - start;
    return tile;
  endfunction

  // Mostly short gaps, some medium, a few long ones.
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: one accepted pixel -> zero, one or two expected result beats.
  // ---------------------------------------------------------------------------
  task automatic scan_pixel(input logic [PIXEL_W-1:0] px, input logic fs);
    int unsigned w, h, t, cp, rp, cit, rit, cs, rs, fidx, addr;
    bit [COLOR_W-1:0] color;
    bit row_end, frame_last, tcol_end, trow_end;
    res_t beat;
    w = fit_range(32'(cfg_width), MAX_WIDTH);
    h = fit_range(32'(cfg_height), MAX_HEIGHT);
    t = fit_range(32'(cfg_tile), MAX_TILE);
    color = px[COLOR_W-1:0];   // alpha byte dropped

    // frame start: restart raster, count and all tile column flags
    if (fs) begin
      col_pos = '0;
      row_pos = '0;
      col_in_tile = '0;
      row_in_tile = '0;
      tiles_found = '0;
      tile_dirty = '{default: 1'b0};
    end

    cp = 32'(col_pos);
    rp = 32'(row_pos);
    cit = 32'(col_in_tile);
    rit = 32'(row_in_tile);
    addr = (rp % MAX_HEIGHT) * MAX_WIDTH + (cp % MAX_WIDTH);
    cs = cp - cit;
    rs = rp - rit;
    fidx = cs % MAX_WIDTH;

    // compare-and-copy; same color leaves flag alone
    if (canvas_copy[addr] != color) tile_dirty[fidx] = 1'b1;
    canvas_copy[addr] = color;

    // >= rather than == so a shrink mid-frame still ends the row/tile/frame
    row_end    = (cp + 1 >= w);
    frame_last = row_end && (rp + 1 >= h);
    tcol_end   = row_end || (cit + 1 >= t);
    trow_end   = (rp + 1 >= h) || (rit + 1 >= t);

    if (tcol_end && trow_end && tile_dirty[fidx]) begin
      tile_dirty[fidx] = 1'b0;
      if (tiles_found != COUNT_LIMIT) tiles_found++;   // saturating count
      beat = '0;
      beat.rect_x = RECT_XY_W'(cfg_ofs_x + cs);
      beat.rect_y = RECT_XY_W'(cfg_ofs_y + rs);
      beat.rect_w = RECT_WH_W'(edge_clip(t, w, cs));
      beat.rect_h = RECT_WH_W'(edge_clip(t, h, rs));
      beat.changed_tiles = tiles_found;
      beat.last = !frame_last;          // frame-end beat follows
      tile_reports_due.push_back(beat);
    end

    if (frame_last) begin
      beat = '0;
      beat.frame_end = 1'b1;
      beat.changed_tiles = tiles_found;
      beat.last = 1'b1;
      tile_reports_due.push_back(beat);
      // next pixel is (0,0) even without a frame start
      col_pos = '0;
      row_pos = '0;
      col_in_tile = '0;
      row_in_tile = '0;
      tiles_found = '0;
    end else if (row_end) begin
      col_pos = '0;
      col_in_tile = '0;
      row_pos++;
      row_in_tile = trow_end ? '0 : TIT_W'(rit + 1);
    end else begin
      col_pos++;
      col_in_tile = tcol_end ? '0 : TIT_W'(cit + 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Pixel driver: presents queued beats, holds them until ready, random gaps
  // between beats. Acceptance feeds the predictor in the same edge.
  // ---------------------------------------------------------------------------
  int unsigned launch_gap;

  always @(posedge clk_i) begin : pix_driver
    bit        free;
    pix_beat_t next_px;
    free = !pix.valid;
    if (pix.valid && pix.ready) begin
      scan_pixel(pix.pixel, pix.frame_start);
      pixels_left--;
      free = 1'b1;
    end
    if (free) begin
      if (launch_gap > 0) begin
        launch_gap--;
        pix.valid <= 1'b0;
      end else if (pix_queue.size() > 0) begin
        next_px = pix_queue.pop_front();
        pix.pixel       <= next_px.pixel;
        pix.frame_start <= next_px.frame_start;
        pix.valid       <= 1'b1;
        launch_gap = pick_gap(src_idle_on);
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random back-pressure, in-order compare of every beat.
  // ---------------------------------------------------------------------------
  int unsigned stall_left;

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : res_monitor
    res_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (tile_reports_due.size() == 0) begin
        $display("%0t: result beat with none expected: x=%0d y=%0d w=%0d h=%0d fe=%0b cnt=%0d last=%0b",
                 $time, res.rect_x, res.rect_y, res.rect_w, res.rect_h, res.frame_end,
                 res.changed_tiles, res.last);
        fail_count++;
      end else begin
        want = tile_reports_due.pop_front();
        compare_field("rect_x", 32'(want.rect_x), 32'(res.rect_x));
        compare_field("rect_y", 32'(want.rect_y), 32'(res.rect_y));
        compare_field("rect_w", 32'(want.rect_w), 32'(res.rect_w));
        compare_field("rect_h", 32'(want.rect_h), 32'(res.rect_h));
        compare_field("frame_end", 32'(want.frame_end), 32'(res.frame_end));
        compare_field("changed_tiles", 32'(want.changed_tiles), 32'(res.changed_tiles));
        compare_field("last", 32'(want.last), 32'(res.last));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left = pick_gap(sink_idle_on);
    end
  end

  // Hang guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // APB write: setup then access; upper bits beyond the field get junk half
  // the time, the register must drop them.
  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    logic [31:0] keep, data;
    case (idx)
      REG_DISPLAY_WIDTH:  keep = (32'd1 << DW_W) - 1;
      REG_DISPLAY_HEIGHT: keep = (32'd1 << DH_W) - 1;
      REG_TILE_SIZE:      keep = (32'd1 << TS_W) - 1;
      default:            keep = (32'd1 << OFS_W) - 1;
    endcase
    data = (val & keep) | ($urandom_range(0, 1) ? ($urandom & ~keep) : 32'd0);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * 4);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DISPLAY_WIDTH:  cfg_width  = data[DW_W-1:0];
      REG_DISPLAY_HEIGHT: cfg_height = data[DH_W-1:0];
      REG_TILE_SIZE:      cfg_tile   = data[TS_W-1:0];
      REG_OFFSET_X:       cfg_ofs_x  = data[OFS_W-1:0];
      default:            cfg_ofs_y  = data[OFS_W-1:0];
    endcase
  endtask

  task automatic queue_pixel(input logic [PIXEL_W-1:0] px, input logic fs);
    pix_queue.push_back('{pixel: px, frame_start: fs});
    pixels_left++;
    sent_items++;
  endtask

  // Block is idle once every pixel is in and every owed beat came out; the
  // pause covers a pixel that caused no result but is still in the pipe.
  task automatic wait_idle();
    while (pixels_left != 0 || tile_reports_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_offset();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // One random phase: new geometry, then frames of one image (up to three if small,
  // else one) with small edits (so most tiles come back clean), plus some broken sequences.
  task automatic run_random_phase(input frame_shape_e shape);
    int unsigned ew, eh, n_frames, len, cut, k, idx, pal0, pal1;
    logic [PIXEL_W-1:0] img [$];
    bit palette, fs;
    src_idle_on  = ($urandom_range(0, 4) != 0);
    sink_idle_on = ($urandom_range(0, 4) != 0);

    case (shape)
      SHAPE_WIDE: begin
        write_reg(REG_DISPLAY_WIDTH, $urandom_range(0, 1) ? 640 : 1023);
        write_reg(REG_DISPLAY_HEIGHT, $urandom_range(0, 1));
        write_reg(REG_TILE_SIZE, $urandom_range(1, 64));
      end
      SHAPE_TALL: begin
        write_reg(REG_DISPLAY_WIDTH, $urandom_range(0, 1));
        write_reg(REG_DISPLAY_HEIGHT, $urandom_range(0, 1) ? 480 : 511);
        write_reg(REG_TILE_SIZE, $urandom_range(0, 1) ? $urandom_range(1, 64)
                                                      : $urandom_range(65, 127));
      end
      default: begin
        // some registers left as they were, so frames may continue mid-raster
        if ($urandom_range(0, 3) != 0)
          write_reg(REG_DISPLAY_WIDTH,
                    ($urandom_range(0, 9) != 0) ? $urandom_range(1, 8) : 0);
        if ($urandom_range(0, 3) != 0)
          write_reg(REG_DISPLAY_HEIGHT,
                    ($urandom_range(0, 9) != 0) ? $urandom_range(1, 6) : 0);
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 9))
            0:       write_reg(REG_TILE_SIZE, 0);
            1:       write_reg(REG_TILE_SIZE, $urandom_range(65, 127));
            default: write_reg(REG_TILE_SIZE, $urandom_range(1, 9));
          endcase
        end
      end
    endcase
    if ($urandom_range(0, 3) != 0) write_reg(REG_OFFSET_X, pick_offset());
    if ($urandom_range(0, 3) != 0) write_reg(REG_OFFSET_Y, pick_offset());

    ew = fit_range(32'(cfg_width), MAX_WIDTH);
    eh = fit_range(32'(cfg_height), MAX_HEIGHT);
    n_frames = (shape == SHAPE_SMALL) ? $urandom_range(1, 3) : 1;
    palette = 1'($urandom_range(0, 1));
    pal0 = $urandom;
    pal1 = $urandom;
    for (idx = 0; idx < ew * eh; idx++)
      img.push_back(palette ? ($urandom_range(0, 1) ? pal0 : pal1) : $urandom);

    for (int f = 0; f < n_frames; f++) begin
      if (f > 0) begin
        k = $urandom_range(0, 3);
        repeat (k) img[$urandom_range(0, img.size() - 1)] = $urandom;
        foreach (img[i]) img[i] = {8'($urandom), img[i][COLOR_W-1:0]};
      end
      fs = (f == 0) ? ($urandom_range(0, 4) != 0) : 1'($urandom_range(0, 1));
      len = img.size();
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);      // cut short
      cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, len) : len; // stray frame start
      for (idx = 0; idx < len; idx++)
        queue_pixel(img[idx], (idx == 0 && fs) || (idx == cut));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase_no;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    pix.valid       = 1'b0;
    pix.pixel       = '0;
    pix.frame_start = 1'b0;
    res.ready       = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Power-up geometry. Same color and alpha-only change must not dirty
    // anything; the first pixel waits out the canvas clearing pass.
    queue_pixel(32'hFF12_3456, 1'b1);
    queue_pixel(32'h0000_0000, 1'b0);
    queue_pixel(32'hFF00_0000, 1'b0);
    wait_idle();

    // 2x2 display, 1-pixel tiles, max offsets (rect_x/y carry into bit 16).
    // First two pixels continue the old raster; the first lies past the new right edge.
    write_reg(REG_DISPLAY_WIDTH, 2);
    write_reg(REG_DISPLAY_HEIGHT, 2);
    write_reg(REG_TILE_SIZE, 1);
    write_reg(REG_OFFSET_X, 65535);
    write_reg(REG_OFFSET_Y, 65535);
    queue_pixel(32'h0000_0001, 1'b0);
    queue_pixel(32'hA5A5_A5A5, 1'b0);
    queue_pixel(32'hFFFF_FFFF, 1'b1);
    queue_pixel(32'h0000_0000, 1'b0);
    queue_pixel(32'h00FF_FFFF, 1'b0);
    queue_pixel(32'h7F00_AA55, 1'b0);
    wait_idle();

    // Zero width/height/tile clamp to 1: every pixel is a whole frame, and
    // frames roll over with no frame start.
    write_reg(REG_DISPLAY_WIDTH, 0);
    write_reg(REG_DISPLAY_HEIGHT, 0);
    write_reg(REG_TILE_SIZE, 0);
    queue_pixel(32'h01FF_FFFF, 1'b0);
    queue_pixel(32'h8000_0000, 1'b0);
    queue_pixel(32'h0000_0000, 1'b1);
    wait_idle();

    // Over-range values clamp to the maxima.
    write_reg(REG_DISPLAY_WIDTH, 1023);
    write_reg(REG_DISPLAY_HEIGHT, 511);
    write_reg(REG_TILE_SIZE, 127);
    write_reg(REG_OFFSET_X, 0);
    write_reg(REG_OFFSET_Y, 32768);
    queue_pixel($urandom, 1'b1);
    repeat (3) queue_pixel($urandom, 1'b0);
    wait_idle();

    // Shrink mid-frame: the column past the new edge ends the row.
    write_reg(REG_DISPLAY_WIDTH, 3);
    write_reg(REG_DISPLAY_HEIGHT, 2);
    write_reg(REG_TILE_SIZE, 2);
    repeat (6) queue_pixel($urandom, 1'b0);
    wait_idle();

    // Random phases; two big-geometry phases mixed in early.
    phase_no = 0;
    while (sent_items < ITEM_TARGET) begin
      if (phase_no == 2) run_random_phase(SHAPE_WIDE);
      else if (phase_no == 6) run_random_phase(SHAPE_TALL);
      else run_random_phase(SHAPE_SMALL);
      wait_idle();
      phase_no++;
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> tile_dirty_compare_copy_top.f
+incdir+src
src/tdcc_pkg.sv
src/tdcc_ifs.sv
src/tdcc_ram.sv
src/tile_dirty_compare_copy_top.sv
tb/sv/tb_tile_dirty_compare_copy_top.sv
